/* hw/rtl/uhrf_pkg.sv */
package uhrf_pkg;

   // One bus transaction or root hub event.
   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  reg_offset;
      logic [31:0] write_data;
      logic [3:0]  root_port;
      logic        low_speed;
   } req_type;

   // One result: read data, error flag and interrupt line level.
   typedef struct packed {
      logic [31:0] read_data;
      logic        bad_access;
      logic        irq;
   } rsp_type;

   // Commands from the register decode to one root port.
   typedef struct packed {
      logic write;
      logic attach;
      logic detach;
      logic reload;
      logic low_speed;
   } port_cmd_type;

   // Transaction function codes.
   localparam logic [2:0] FUNC_READ   = 3'd0;
   localparam logic [2:0] FUNC_WRITE  = 3'd1;
   localparam logic [2:0] FUNC_FRAME  = 3'd2;
   localparam logic [2:0] FUNC_ATTACH = 3'd3;
   localparam logic [2:0] FUNC_DETACH = 3'd4;

   // Operational register offsets.
   localparam logic [7:0] OFF_REVISION       = 8'h00;
   localparam logic [7:0] OFF_CONTROL        = 8'h04;
   localparam logic [7:0] OFF_CMD_STATUS     = 8'h08;
   localparam logic [7:0] OFF_INT_STATUS     = 8'h0C;
   localparam logic [7:0] OFF_INT_ENABLE     = 8'h10;
   localparam logic [7:0] OFF_INT_DISABLE    = 8'h14;
   localparam logic [7:0] OFF_HCCA           = 8'h18;
   localparam logic [7:0] OFF_PERIOD_CUR_ED  = 8'h1C;
   localparam logic [7:0] OFF_CTRL_HEAD_ED   = 8'h20;
   localparam logic [7:0] OFF_CTRL_CUR_ED    = 8'h24;
   localparam logic [7:0] OFF_BULK_HEAD_ED   = 8'h28;
   localparam logic [7:0] OFF_BULK_CUR_ED    = 8'h2C;
   localparam logic [7:0] OFF_DONE_HEAD      = 8'h30;
   localparam logic [7:0] OFF_FM_INTERVAL    = 8'h34;
   localparam logic [7:0] OFF_FM_REMAINING   = 8'h38;
   localparam logic [7:0] OFF_FM_NUMBER      = 8'h3C;
   localparam logic [7:0] OFF_PERIODIC_START = 8'h40;
   localparam logic [7:0] OFF_LS_THRESHOLD   = 8'h44;
   localparam logic [7:0] OFF_RH_DESC_A      = 8'h48;
   localparam logic [7:0] OFF_RH_DESC_B      = 8'h4C;
   localparam logic [7:0] OFF_RH_STATUS      = 8'h50;
   localparam logic [7:0] OFF_PORT_BASE      = 8'h54;

   // Register values and masks.
   localparam logic [31:0] REVISION_VAL       = 32'h0000_0010;
   localparam logic [31:0] FM_INTERVAL_RST    = 32'h2778_2EDF;
   localparam logic [31:0] FM_REMAINING_VAL   = 32'h0000_2EDF;
   localparam logic [13:0] PERIODIC_START_RST = 14'h2A2F;
   localparam logic [11:0] LS_THRESHOLD_RST   = 12'h628;
   localparam logic [31:0] RH_DESC_A_BASE     = 32'h0200_0000;
   localparam logic [31:0] HCCA_MASK          = 32'hFFFF_FF00;
   localparam logic [31:0] ED_MASK            = 32'hFFFF_FFF0;

   // Interrupt bits.
   localparam logic [31:0] INT_SF          = 32'h0000_0004;
   localparam logic [31:0] INT_RHSC        = 32'h0000_0040;
   localparam logic [31:0] INT_MIE         = 32'h8000_0000;
   localparam logic [31:0] INT_VALID       = 32'h4000_007F;
   localparam logic [31:0] INT_ENABLE_MASK = INT_VALID | INT_MIE;

   // Root port status bit positions.
   localparam int PS_CCS_BIT  = 0;
   localparam int PS_PES_BIT  = 1;
   localparam int PS_PRS_BIT  = 4;
   localparam int PS_PPS_BIT  = 8;
   localparam int PS_LSDA_BIT = 9;
   localparam int PS_CSC_BIT  = 16;
   localparam int PS_PRSC_BIT = 20;

   localparam int NUM_LIST_PTRS = 6;

endpackage

/* hw/rtl/uhrf_port.sv */
module uhrf_port import uhrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  port_cmd_type cmd,
   input  logic [31:0]  write_data,
   output logic [31:0]  status,
   output logic         rhsc
);

   logic connected_ff, connected_in;
   logic low_ff, low_in;
   logic ccs_ff, ccs_in;
   logic pes_ff, pes_in;
   logic lsda_ff, lsda_in;
   logic csc_ff, csc_in;
   logic prsc_ff, prsc_in;

   // A port reset request completes at once, but only with a device present.
   assign rhsc = cmd.write && write_data[PS_PRS_BIT] && ccs_ff;

   always_comb begin
      connected_in = connected_ff;
      low_in       = low_ff;
      ccs_in       = ccs_ff;
      pes_in       = pes_ff;
      lsda_in      = lsda_ff;
      csc_in       = csc_ff;
      prsc_in      = prsc_ff;
      if (cmd.reload) begin
         ccs_in  = connected_ff;
         csc_in  = connected_ff;
         lsda_in = connected_ff && low_ff;
         pes_in  = 1'b0;
         prsc_in = 1'b0;
      end else if (cmd.attach) begin
         connected_in = 1'b1;
         low_in       = cmd.low_speed;
         ccs_in       = 1'b1;
         csc_in       = 1'b1;
         lsda_in      = cmd.low_speed;
      end else if (cmd.detach) begin
         connected_in = 1'b0;
         ccs_in       = 1'b0;
         pes_in       = 1'b0;
         csc_in       = 1'b1;
      end else if (cmd.write) begin
         csc_in  = csc_ff && !write_data[PS_CSC_BIT];
         prsc_in = prsc_ff && !write_data[PS_PRSC_BIT];
         if (rhsc) begin
            pes_in  = 1'b1;
            prsc_in = 1'b1;
         end
         if (write_data[PS_PES_BIT] && ccs_ff) begin
            pes_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         low_ff       <= 1'b0;
         ccs_ff       <= 1'b0;
         pes_ff       <= 1'b0;
         lsda_ff      <= 1'b0;
         csc_ff       <= 1'b0;
         prsc_ff      <= 1'b0;
      end else begin
         connected_ff <= connected_in;
         low_ff       <= low_in;
         ccs_ff       <= ccs_in;
         pes_ff       <= pes_in;
         lsda_ff      <= lsda_in;
         csc_ff       <= csc_in;
         prsc_ff      <= prsc_in;
      end
   end

   // Port power always reads as on, and nothing ever clears it.
   always_comb begin
      status              = '0;
      status[PS_CCS_BIT]  = ccs_ff;
      status[PS_PES_BIT]  = pes_ff;
      status[PS_PPS_BIT]  = 1'b1;
      status[PS_LSDA_BIT] = lsda_ff;
      status[PS_CSC_BIT]  = csc_ff;
      status[PS_PRSC_BIT] = prsc_ff;
   end

endmodule

/* hw/rtl/usb_host_register_file.sv */
// OHCI operational register file with root hub ports.
//
// Request channel: a transaction is taken at a rising clock edge where start
// is high and busy is low. busy is held low, so a new transaction can be
// issued every cycle. req_item carries the function (read, write, frame
// tick, device attach, device detach), the register offset, write data and
// the root port number with its speed.
//
// Result channel: every transaction produces exactly one result on rsp_item,
// marked by rsp_strobe for a single cycle. The accepting edge registers the
// request, and the next edge applies it to the registers, captures the
// result and raises the strobe. The receiver has no way to stall, so
// results stream out at the request rate of one per cycle.
//
// Reset returns every register to its OHCI default with no device attached.
// A write of HostControllerReset reloads the registers in the same way but
// keeps attached devices attached. The irq bit reflects the interrupt state
// after the transaction has been applied.
module usb_host_register_file import uhrf_pkg::*; #(
   parameter int NUM_PORTS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int PORT_END = 32'(OFF_PORT_BASE) + 4 * NUM_PORTS;

   // Request register.
   logic    req_valid_ff;
   req_type req_ff;

   // Operational registers.
   logic [31:0] control_ff, control_in;
   logic [31:0] cmd_status_ff, cmd_status_in;
   logic [31:0] int_status_ff, int_status_in;
   logic [31:0] int_enable_ff, int_enable_in;
   logic [31:0] hcca_ff, hcca_in;
   logic [31:0] list_ptr_ff [NUM_LIST_PTRS];
   logic [31:0] list_ptr_in [NUM_LIST_PTRS];
   logic [31:0] fm_interval_ff, fm_interval_in;
   logic [15:0] fm_number_ff, fm_number_in;
   logic [13:0] periodic_start_ff, periodic_start_in;
   logic [11:0] ls_threshold_ff, ls_threshold_in;

   // Result register.
   logic    rsp_strobe_ff;
   rsp_type rsp_ff, rsp_in;

   // Decode and port signals.
   logic [7:0]  port_rel;
   logic [3:0]  port_num;
   logic        port_sel;
   logic        root_port_ok;
   logic [2:0]  list_idx;
   logic        port_wr;
   logic        port_att;
   logic        port_det;
   logic        reload;
   logic [31:0] int_status_base;
   logic [31:0] int_raise;
   logic [31:0] read_val;
   logic        read_hit;
   logic [31:0] rd_data;
   logic        bad;
   logic [31:0] port_read;
   port_cmd_type          port_cmd    [NUM_PORTS];
   logic [31:0]           port_word   [NUM_PORTS];
   logic [NUM_PORTS-1:0]  port_rhsc;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
   end

   // Offset decode. Any byte offset inside a port's word selects that port.
   assign port_rel      = req_ff.reg_offset - OFF_PORT_BASE;
   assign port_num      = port_rel[5:2];
   assign port_sel      = (req_ff.reg_offset >= OFF_PORT_BASE) &&
                          ({1'b0, req_ff.reg_offset} < 9'(PORT_END));
   assign root_port_ok  = req_ff.root_port < 4'(NUM_PORTS);
   assign list_idx      = 3'((req_ff.reg_offset - OFF_PERIOD_CUR_ED) >> 2);

   // Port status read select.
   always_comb begin
      port_read = '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (port_num == 4'(p)) begin
            port_read = port_read | port_word[p];
         end
      end
   end

   // Register read.
   always_comb begin
      read_val = '0;
      read_hit = 1'b1;
      unique case (req_ff.reg_offset)
         OFF_REVISION:       read_val = REVISION_VAL;
         OFF_CONTROL:        read_val = control_ff;
         OFF_CMD_STATUS:     read_val = cmd_status_ff;
         OFF_INT_STATUS:     read_val = int_status_ff;
         OFF_INT_ENABLE,
         OFF_INT_DISABLE:    read_val = int_enable_ff;
         OFF_HCCA:           read_val = hcca_ff;
         OFF_PERIOD_CUR_ED,
         OFF_CTRL_HEAD_ED,
         OFF_CTRL_CUR_ED,
         OFF_BULK_HEAD_ED,
         OFF_BULK_CUR_ED,
         OFF_DONE_HEAD:      read_val = list_ptr_ff[list_idx];
         OFF_FM_INTERVAL:    read_val = fm_interval_ff;
         OFF_FM_REMAINING:   read_val = FM_REMAINING_VAL;
         OFF_FM_NUMBER:      read_val = 32'(fm_number_ff);
         OFF_PERIODIC_START: read_val = 32'(periodic_start_ff);
         OFF_LS_THRESHOLD:   read_val = 32'(ls_threshold_ff);
         OFF_RH_DESC_A:      read_val = RH_DESC_A_BASE | 32'(NUM_PORTS);
         OFF_RH_DESC_B,
         OFF_RH_STATUS:      read_val = '0;
         default: begin
            if (port_sel) begin
               read_val = port_read;
            end else begin
               read_hit = 1'b0;
            end
         end
      endcase
   end

   // Transaction execution.
   always_comb begin
      control_in        = control_ff;
      cmd_status_in     = cmd_status_ff;
      int_status_base   = int_status_ff;
      int_enable_in     = int_enable_ff;
      hcca_in           = hcca_ff;
      list_ptr_in       = list_ptr_ff;
      fm_interval_in    = fm_interval_ff;
      fm_number_in      = fm_number_ff;
      periodic_start_in = periodic_start_ff;
      ls_threshold_in   = ls_threshold_ff;
      int_raise         = '0;
      rd_data           = '0;
      bad               = 1'b0;
      port_wr           = 1'b0;
      port_att          = 1'b0;
      port_det          = 1'b0;
      reload            = 1'b0;
      if (req_valid_ff) begin
         case (req_ff.func)
            FUNC_READ: begin
               rd_data = read_val;
               bad     = !read_hit;
            end
            FUNC_WRITE: begin
               unique case (req_ff.reg_offset)
                  OFF_CONTROL: control_in = req_ff.write_data;
                  OFF_CMD_STATUS: begin
                     if (req_ff.write_data[0]) begin
                        reload = 1'b1;
                     end else begin
                        cmd_status_in = req_ff.write_data;
                     end
                  end
                  OFF_INT_STATUS:
                     int_status_base = int_status_ff & ~req_ff.write_data;
                  OFF_INT_ENABLE:
                     int_enable_in = int_enable_ff |
                                     (req_ff.write_data & INT_ENABLE_MASK);
                  OFF_INT_DISABLE:
                     int_enable_in = int_enable_ff &
                                     ~(req_ff.write_data & INT_ENABLE_MASK);
                  OFF_HCCA: hcca_in = req_ff.write_data & HCCA_MASK;
                  OFF_PERIOD_CUR_ED,
                  OFF_CTRL_HEAD_ED,
                  OFF_CTRL_CUR_ED,
                  OFF_BULK_HEAD_ED,
                  OFF_BULK_CUR_ED,
                  OFF_DONE_HEAD:
                     list_ptr_in[list_idx] = req_ff.write_data & ED_MASK;
                  OFF_FM_INTERVAL: fm_interval_in = req_ff.write_data;
                  OFF_FM_NUMBER: fm_number_in = req_ff.write_data[15:0];
                  OFF_PERIODIC_START: periodic_start_in = req_ff.write_data[13:0];
                  OFF_LS_THRESHOLD: ls_threshold_in = req_ff.write_data[11:0];
                  OFF_REVISION,
                  OFF_FM_REMAINING,
                  OFF_RH_DESC_A,
                  OFF_RH_DESC_B,
                  OFF_RH_STATUS: begin
                  end
                  default: begin
                     if (port_sel) begin
                        port_wr = 1'b1;
                     end else begin
                        bad = 1'b1;
                     end
                  end
               endcase
            end
            FUNC_FRAME: begin
               fm_number_in = fm_number_ff + 16'd1;
               int_raise    = INT_SF;
            end
            FUNC_ATTACH: begin
               if (root_port_ok) begin
                  port_att  = 1'b1;
                  int_raise = INT_RHSC;
               end else begin
                  bad = 1'b1;
               end
            end
            FUNC_DETACH: begin
               if (root_port_ok) begin
                  port_det  = 1'b1;
                  int_raise = INT_RHSC;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // HostControllerReset brings every register back to its default.
      if (reload) begin
         control_in        = '0;
         cmd_status_in     = '0;
         int_status_base   = '0;
         int_enable_in     = '0;
         hcca_in           = '0;
         for (int i = 0; i < NUM_LIST_PTRS; i++) begin
            list_ptr_in[i] = '0;
         end
         fm_interval_in    = FM_INTERVAL_RST;
         fm_number_in      = '0;
         periodic_start_in = PERIODIC_START_RST;
         ls_threshold_in   = LS_THRESHOLD_RST;
      end
   end

   // Root ports.
   always_comb begin
      for (int p = 0; p < NUM_PORTS; p++) begin
         port_cmd[p].write     = port_wr && (port_num == 4'(p));
         port_cmd[p].attach    = port_att && (req_ff.root_port == 4'(p));
         port_cmd[p].detach    = port_det && (req_ff.root_port == 4'(p));
         port_cmd[p].reload    = reload;
         port_cmd[p].low_speed = req_ff.low_speed;
      end
   end

   for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
      uhrf_port u_port (
         .clock      (clock),
         .reset      (reset),
         .cmd        (port_cmd[p]),
         .write_data (req_ff.write_data),
         .status     (port_word[p]),
         .rhsc       (port_rhsc[p])
      );
   end

   // A completed port reset raises the root hub status change interrupt.
   always_comb begin
      int_status_in = int_status_base |
                      ((int_raise | ((|port_rhsc) ? INT_RHSC : '0)) & INT_VALID);
   end

   // The result reports irq as it stands once this transaction is applied.
   always_comb begin
      rsp_in.read_data  = rd_data;
      rsp_in.bad_access = bad;
      rsp_in.irq        = ((int_enable_in & INT_MIE) != '0) &&
                          ((int_status_in & int_enable_in & ~INT_MIE) != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff        <= '0;
         cmd_status_ff     <= '0;
         int_status_ff     <= '0;
         int_enable_ff     <= '0;
         hcca_ff           <= '0;
         for (int i = 0; i < NUM_LIST_PTRS; i++) begin
            list_ptr_ff[i] <= '0;
         end
         fm_interval_ff    <= FM_INTERVAL_RST;
         fm_number_ff      <= '0;
         periodic_start_ff <= PERIODIC_START_RST;
         ls_threshold_ff   <= LS_THRESHOLD_RST;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         control_ff        <= control_in;
         cmd_status_ff     <= cmd_status_in;
         int_status_ff     <= int_status_in;
         int_enable_ff     <= int_enable_in;
         hcca_ff           <= hcca_in;
         list_ptr_ff       <= list_ptr_in;
         fm_interval_ff    <= fm_interval_in;
         fm_number_ff      <= fm_number_in;
         periodic_start_ff <= periodic_start_in;
         ls_threshold_ff   <= ls_threshold_in;
         rsp_strobe_ff     <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* hw/rtl/uhrf_checker.sv */
module uhrf_checker import uhrf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Every transaction taken gives one result, and no result appears without one.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == ($past(start && !busy, 2) && !$past(reset, 2) && !$past(reset, 1)))
      else $error("result strobe does not match an accepted transaction");

   // Read data is zero for anything other than a read.
   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.read_data != '0) |-> $past(req_item.func == FUNC_READ, 2))
      else $error("nonzero read data on a non-read transaction");

   // A frame tick is never an error.
   a_frame_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_item.func == FUNC_FRAME, 2) |-> !rsp_item.bad_access)
      else $error("frame tick flagged as bad access");

   // The revision register always reads its fixed value.
   a_revision_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_item.func == FUNC_READ, 2) &&
      $past(req_item.reg_offset == OFF_REVISION, 2)
      |-> (rsp_item.read_data == REVISION_VAL) && !rsp_item.bad_access)
      else $error("revision register read returned a wrong value");

endmodule

bind usb_host_register_file uhrf_checker u_uhrf_checker (.*);

/* tb/testbench.sv */
module testbench import uhrf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built with four root ports.
   localparam int PORT_COUNT = 4;

   // Function codes 5 to 7 carry no meaning and must leave all state alone.
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   // HostControllerReset lives in bit 0 of HcCommandStatus.
   localparam logic [31:0] CMD_HCR = 32'h0000_0001;

   // Offsets that decode to nothing: the first byte past the last port and
   // the very top of the window.
   localparam logic [7:0] OFF_PAST_PORTS = OFF_PORT_BASE + 8'(4 * PORT_COUNT);
   localparam logic [7:0] OFF_TOP        = 8'hFF;
   localparam int         LAST_REG_SLOT  = 20;

   // Root port status bits, built from the bit positions in the package.
   localparam logic [31:0] PS_CCS         = 32'h1 << PS_CCS_BIT;
   localparam logic [31:0] PS_PES         = 32'h1 << PS_PES_BIT;
   localparam logic [31:0] PS_PRS         = 32'h1 << PS_PRS_BIT;
   localparam logic [31:0] PS_PPS         = 32'h1 << PS_PPS_BIT;
   localparam logic [31:0] PS_LSDA        = 32'h1 << PS_LSDA_BIT;
   localparam logic [31:0] PS_CSC         = 32'h1 << PS_CSC_BIT;
   localparam logic [31:0] PS_PRSC        = 32'h1 << PS_PRSC_BIT;
   localparam logic [31:0] PS_CHANGE_MASK = 32'h001F_0000;

   // Run shape. The sender idles about 18 times in a hundred, except inside
   // a quiet stretch of the random part where it issues back to back.
   localparam int RANDOM_ITEMS  = 1450;
   localparam int IDLE_PCT      = 18;
   localparam int QUIET_FROM    = 500;
   localparam int QUIET_TO      = 900;
   localparam int DRAIN_EVERY   = 180;
   localparam int RSP_LATENCY   = 2;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      req_type req;
      bit      drain_first;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   pending_type pending_req_q[$];
   rsp_type     expected_rsp_q[$];
   int          items_total = 0;
   int          items_accepted = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   // Shadow copy of the operational registers and root hub state.
   logic [31:0] hc_control;
   logic [31:0] hc_cmd_status;
   logic [31:0] hc_int_status;
   logic [31:0] hc_int_enable;
   logic [31:0] hc_hcca;
   logic [31:0] hc_list_ptr [NUM_LIST_PTRS];
   logic [31:0] hc_fm_interval;
   logic [15:0] hc_fm_number;
   logic [13:0] hc_periodic_start;
   logic [11:0] hc_ls_threshold;
   logic [31:0] hc_port_word [PORT_COUNT];
   logic        dev_present [PORT_COUNT];
   logic        dev_low_speed [PORT_COUNT];

   usb_host_register_file #(.NUM_PORTS(PORT_COUNT)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Reloads every register to its OHCI default. Attached devices survive
   // the reload, so their ports come back with connect and connect change.
   function automatic void hc_reload();
      hc_control        = '0;
      hc_cmd_status     = '0;
      hc_int_status     = '0;
      hc_int_enable     = '0;
      hc_hcca           = '0;
      foreach (hc_list_ptr[i]) hc_list_ptr[i] = '0;
      hc_fm_interval    = FM_INTERVAL_RST;
      hc_fm_number      = '0;
      hc_periodic_start = PERIODIC_START_RST;
      hc_ls_threshold   = LS_THRESHOLD_RST;
      for (int p = 0; p < PORT_COUNT; p++) begin
         hc_port_word[p] = PS_PPS;
         if (dev_present[p]) begin
            hc_port_word[p] |= PS_CCS | PS_CSC;
            if (dev_low_speed[p]) hc_port_word[p] |= PS_LSDA;
         end
      end
   endfunction

   // Returns the root port that an offset selects, or -1. Any byte inside a
   // port's four-byte window selects that port.
   function automatic int port_slot(logic [7:0] off);
      if (off >= OFF_PORT_BASE && off < OFF_PAST_PORTS) return (off - OFF_PORT_BASE) >> 2;
      return -1;
   endfunction

   function automatic logic irq_level();
      return hc_int_enable[31] && ((hc_int_status & hc_int_enable & ~INT_MIE) != '0);
   endfunction

   // Applies one transaction to the shadow registers and returns the result
   // that the block must produce for it.
   function automatic rsp_type hc_apply(req_type t);
      rsp_type     r;
      int          p;
      logic [31:0] v;
      r = '0;
      v = t.write_data;
      p = port_slot(t.reg_offset);
      case (t.func)
         FUNC_READ: begin
            case (t.reg_offset)
               OFF_REVISION:       r.read_data = REVISION_VAL;
               OFF_CONTROL:        r.read_data = hc_control;
               OFF_CMD_STATUS:     r.read_data = hc_cmd_status;
               OFF_INT_STATUS:     r.read_data = hc_int_status;
               OFF_INT_ENABLE,
               OFF_INT_DISABLE:    r.read_data = hc_int_enable;
               OFF_HCCA:           r.read_data = hc_hcca;
               OFF_PERIOD_CUR_ED, OFF_CTRL_HEAD_ED, OFF_CTRL_CUR_ED,
               OFF_BULK_HEAD_ED, OFF_BULK_CUR_ED, OFF_DONE_HEAD:
                  r.read_data = hc_list_ptr[(t.reg_offset - OFF_PERIOD_CUR_ED) >> 2];
               OFF_FM_INTERVAL:    r.read_data = hc_fm_interval;
               OFF_FM_REMAINING:   r.read_data = FM_REMAINING_VAL;
               OFF_FM_NUMBER:      r.read_data = {16'h0, hc_fm_number};
               OFF_PERIODIC_START: r.read_data = {18'h0, hc_periodic_start};
               OFF_LS_THRESHOLD:   r.read_data = {20'h0, hc_ls_threshold};
               OFF_RH_DESC_A:      r.read_data = RH_DESC_A_BASE | PORT_COUNT;
               OFF_RH_DESC_B,
               OFF_RH_STATUS:      r.read_data = '0;
               default: begin
                  if (p >= 0) r.read_data = hc_port_word[p];
                  else r.bad_access = 1'b1;
               end
            endcase
         end
         FUNC_WRITE: begin
            case (t.reg_offset)
               OFF_REVISION, OFF_FM_REMAINING, OFF_RH_DESC_A, OFF_RH_DESC_B,
               OFF_RH_STATUS: ;
               OFF_CONTROL: hc_control = v;
               OFF_CMD_STATUS: begin
                  if ((v & CMD_HCR) != '0) hc_reload();
                  else hc_cmd_status = v;
               end
               OFF_INT_STATUS:     hc_int_status &= ~v;
               OFF_INT_ENABLE:     hc_int_enable |= v & INT_ENABLE_MASK;
               OFF_INT_DISABLE:    hc_int_enable &= ~(v & INT_ENABLE_MASK);
               OFF_HCCA:           hc_hcca = v & HCCA_MASK;
               OFF_PERIOD_CUR_ED, OFF_CTRL_HEAD_ED, OFF_CTRL_CUR_ED,
               OFF_BULK_HEAD_ED, OFF_BULK_CUR_ED, OFF_DONE_HEAD:
                  hc_list_ptr[(t.reg_offset - OFF_PERIOD_CUR_ED) >> 2] = v & ED_MASK;
               OFF_FM_INTERVAL:    hc_fm_interval = v;
               OFF_FM_NUMBER:      hc_fm_number = v[15:0];
               OFF_PERIODIC_START: hc_periodic_start = v[13:0];
               OFF_LS_THRESHOLD:   hc_ls_threshold = v[11:0];
               default: begin
                  if (p < 0) begin
                     r.bad_access = 1'b1;
                  end else begin
                     hc_port_word[p] &= ~(v & PS_CHANGE_MASK);
                     // A port reset finishes at once and leaves the port enabled.
                     if ((v & PS_PRS) != '0 && (hc_port_word[p] & PS_CCS) != '0) begin
                        hc_port_word[p] |= PS_PES | PS_PRSC;
                        hc_port_word[p] &= ~PS_PRS;
                        hc_int_status |= INT_RHSC & INT_VALID;
                     end
                     if ((v & PS_PES) != '0 && (hc_port_word[p] & PS_CCS) != '0)
                        hc_port_word[p] |= PS_PES;
                     if ((v & PS_PPS) != '0) hc_port_word[p] |= PS_PPS;
                  end
               end
            endcase
         end
         FUNC_FRAME: begin
            hc_fm_number  = hc_fm_number + 16'd1;
            hc_int_status |= INT_SF & INT_VALID;
         end
         FUNC_ATTACH: begin
            if (t.root_port >= PORT_COUNT) begin
               r.bad_access = 1'b1;
            end else begin
               dev_present[t.root_port]   = 1'b1;
               dev_low_speed[t.root_port] = t.low_speed;
               hc_port_word[t.root_port] |= PS_CCS | PS_CSC;
               if (t.low_speed) hc_port_word[t.root_port] |= PS_LSDA;
               else hc_port_word[t.root_port] &= ~PS_LSDA;
               hc_int_status |= INT_RHSC & INT_VALID;
            end
         end
         FUNC_DETACH: begin
            if (t.root_port >= PORT_COUNT) begin
               r.bad_access = 1'b1;
            end else begin
               dev_present[t.root_port] = 1'b0;
               hc_port_word[t.root_port] &= ~(PS_CCS | PS_PES);
               hc_port_word[t.root_port] |= PS_CSC;
               hc_int_status |= INT_RHSC & INT_VALID;
            end
         end
         default: ;
      endcase
      r.irq = irq_level();
      return r;
   endfunction

   task automatic queue_req(input logic [2:0] f, input logic [7:0] off, input logic [31:0] data,
                            input logic [3:0] port, input logic ls, input bit drain_first);
      pending_type e;
      e.req.func        = f;
      e.req.reg_offset  = off;
      e.req.write_data  = data;
      e.req.root_port   = port;
      e.req.low_speed   = ls;
      e.drain_first     = drain_first;
      pending_req_q.push_back(e);
      items_total++;
   endtask

   // Builds one random transaction. Most offsets name a real register or a
   // port, so that writes land and later reads see their effect; a few are
   // drawn from the whole byte range to reach the undecoded holes.
   task automatic queue_random(input bit drain_first);
      int          pick;
      logic [2:0]  f;
      logic [7:0]  off;
      logic [31:0] data;
      logic [3:0]  port;
      pick = $urandom_range(99);
      if (pick < 30) f = FUNC_READ;
      else if (pick < 65) f = FUNC_WRITE;
      else if (pick < 75) f = FUNC_FRAME;
      else if (pick < 86) f = FUNC_ATTACH;
      else if (pick < 96) f = FUNC_DETACH;
      else f = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      pick = $urandom_range(9);
      if (pick < 7) off = 8'($urandom_range(LAST_REG_SLOT) * 4);
      else if (pick < 9) off = OFF_PORT_BASE + 8'($urandom_range(4 * PORT_COUNT - 1));
      else off = 8'($urandom_range(255));
      data = $urandom;
      // A controller reset wipes everything, so it is kept rare.
      if (off == OFF_CMD_STATUS && $urandom_range(19) != 0) data &= ~CMD_HCR;
      // Frame numbers close to the top let the counter wrap on a tick.
      if (off == OFF_FM_NUMBER && $urandom_range(3) == 0)
         data[15:0] = 16'hFFFF - 16'($urandom_range(3));
      if ($urandom_range(9) < 8) port = 4'($urandom_range(PORT_COUNT - 1));
      else port = 4'($urandom_range(15));
      queue_req(f, off, data, port, 1'($urandom_range(1)), drain_first);
   endtask

   // Driver. A transaction is taken at an edge where start is high and busy
   // is low; its expected result is computed right there, in the order the
   // block takes them. A held request stays on the bus until taken. Items
   // marked for draining wait until every outstanding result has come back.
   always @(posedge clock) begin
      bit          pause_now;
      pending_type next_item;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp_q.push_back(hc_apply(req_item));
            items_accepted++;
         end
         if (!(start && busy)) begin
            pause_now = (items_accepted < QUIET_FROM || items_accepted >= QUIET_TO)
                        && $urandom_range(99) < IDLE_PCT;
            if (pending_req_q.size() != 0 && !pause_now &&
                !(pending_req_q[0].drain_first && expected_rsp_q.size() != 0)) begin
               next_item = pending_req_q.pop_front();
               start    <= 1'b1;
               req_item <= next_item.req;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. The block cannot be stalled, so every strobed cycle is a
   // result that must match the oldest expectation field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result with no transaction outstanding: read_data %h", rsp_item.read_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_item.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_item.read_data);
               error_count++;
            end
            if (rsp_item.bad_access !== want.bad_access) begin
               $error("bad_access: expected %b, got %b", want.bad_access, rsp_item.bad_access);
               error_count++;
            end
            if (rsp_item.irq !== want.irq) begin
               $error("irq: expected %b, got %b", want.irq, rsp_item.irq);
               error_count++;
            end
         end
      end
   end

   // Watchdog. A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** usb_host_register_file: FAILED **");
         $finish;
      end
   end

   initial begin
      foreach (dev_present[p]) begin
         dev_present[p]   = 1'b0;
         dev_low_speed[p] = 1'b0;
      end
      hc_reload();

      // Directed opening: reset values, masking, port handling, interrupt
      // delivery, counter wrap, bad offsets and ports, spare function codes,
      // and finally the controller reset command with devices attached.
      queue_req(FUNC_READ, OFF_REVISION, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_FM_INTERVAL, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_PERIODIC_START, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_LS_THRESHOLD, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_RH_DESC_A, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_PORT_BASE, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_INT_ENABLE, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, '0, '0, 4'd0, 1'b1, 1'b0);
      queue_req(FUNC_ATTACH, '0, '1, 4'(PORT_COUNT - 1), 1'b0, 1'b0);
      queue_req(FUNC_ATTACH, '0, '0, 4'hF, 1'b1, 1'b0);
      queue_req(FUNC_READ, OFF_PORT_BASE + 8'd3, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_PORT_BASE, PS_PRS, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_PORT_BASE + 8'd1, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_PORT_BASE, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_DETACH, '0, '0, 4'(PORT_COUNT - 1), 1'b0, 1'b0);
      queue_req(FUNC_DETACH, '0, '0, 4'(PORT_COUNT), 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_INT_STATUS, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_FM_NUMBER, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_FRAME, '1, '1, '1, 1'b1, 1'b0);
      queue_req(FUNC_READ, OFF_FM_NUMBER, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_HCCA, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_DONE_HEAD, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_PERIODIC_START, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_PAST_PORTS, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_READ, OFF_TOP, '0, '0, 1'b0, 1'b0);
      queue_req(FUNC_SPARE_LO, OFF_CONTROL, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_SPARE_HI, OFF_CONTROL, '1, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_CMD_STATUS, ~CMD_HCR, '0, 1'b0, 1'b0);
      queue_req(FUNC_WRITE, OFF_CMD_STATUS, CMD_HCR, '0, 1'b0, 1'b1);
      queue_req(FUNC_READ, OFF_PORT_BASE, '0, '0, 1'b0, 1'b0);

      // Random part, with a full drain before every so many transactions.
      for (int n = 0; n < RANDOM_ITEMS; n++)
         queue_random(n % DRAIN_EVERY == DRAIN_EVERY - 1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 6) @(posedge clock);

      if (error_count == 0) begin
         $display("** usb_host_register_file: PASSED **");
      end else begin
         $display("** usb_host_register_file: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/uhrf_pkg.sv
hw/rtl/uhrf_port.sv
hw/rtl/usb_host_register_file.sv
hw/rtl/uhrf_checker.sv
tb/testbench.sv
